// ===== rtl/ugb_pkg.sv =====
// ugb_pkg: shared constants of the uniform grid binner
// operation and status codes, fixed point grid offset, cell tag width
// no dependencies
`default_nettype none

package ugb_pkg;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_STORED   = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_OUTSIDE  = 2'd2;
  localparam logic [1:0] ST_CLEARED  = 2'd3;

  // payload widths fixed by the interface
  localparam int POS_W    = 16;
  localparam int ID_W     = 10;
  localparam int LIMIT_W  = 4;
  localparam int CELLIX_W = 12;
  localparam int SLOTIX_W = 3;
  localparam int STATUS_W = 2;

  // Q2.14 position plus 1.5, then one cell per 1/16
  localparam logic signed [POS_W:0] GRID_OFFSET = 17'sd24576;
  localparam int COORD_SHIFT = 10;
  localparam int COORD_W     = POS_W - COORD_SHIFT;

  // frame tag stored with each cell count, zero marks a swept entry
  localparam int TAG_W = 8;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

endpackage

`default_nettype wire

// ===== rtl/uniform_grid_binning.sv =====
// uniform_grid_binning: broad-phase binner, appends object ids to grid cell lists
// cell counts live in a tagged count memory, ids in a slot memory
// depends on ugb_pkg
//
//  channel   direction  handshake            payload
//  insert    in         start_i & !busy_o    operation_i, pos_x_i, pos_y_i, object_id_i
//  result    out        done_o (one cycle)   cell_index_o, slot_index_o, status_o
//  config    in         cfg_we_i             cfg_wdata_i (cell_limit)
//
// One item per cycle while busy_o is low; each result shows on done_o the cycle after its beat.
// The count memory is read at the beat and written back the next cycle;
// a same-cell insert right behind is served from the write forwarding register.
// A clear bumps the frame tag; after reset and after every 255th clear a sweep
// rewrites all GRID_SIDE*GRID_SIDE count entries (2304 at 48) with busy_o high.
// Results cannot be stalled.
`default_nettype none

module uniform_grid_binning import ugb_pkg::*; #(
  parameter int GRID_SIDE      = 48,
  parameter int SLOTS_PER_CELL = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic                  operation_i,
  input  wire logic [POS_W-1:0]      pos_x_i,
  input  wire logic [POS_W-1:0]      pos_y_i,
  input  wire logic [ID_W-1:0]       object_id_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [LIMIT_W-1:0]    cfg_wdata_i,
  output logic                       done_o,
  output logic [CELLIX_W-1:0]        cell_index_o,
  output logic [SLOTIX_W-1:0]        slot_index_o,
  output logic [STATUS_W-1:0]        status_o
);

  localparam int Cells     = GRID_SIDE * GRID_SIDE;
  localparam int CellW     = $clog2(Cells);
  localparam int CntW      = $clog2(SLOTS_PER_CELL + 1);
  localparam int WordW     = TAG_W + CntW;
  localparam int SlotAddrW = $clog2(Cells * SLOTS_PER_CELL);
  localparam logic [TAG_W-1:0] TagMax = {TAG_W{1'b1}};

  // memories
  logic [WordW-1:0] cnt_mem [Cells];
  logic [ID_W-1:0]  slot_mem [Cells * SLOTS_PER_CELL];

  // control registers
  logic                 sweep_q, sweep_d;
  logic [CellW-1:0]     sweep_addr_q, sweep_addr_d;
  logic [TAG_W-1:0]     epoch_q, epoch_d;
  logic [LIMIT_W-1:0]   cell_limit_q;
  logic                 s1_valid_q;
  logic                 fw_valid_q;

  // payload registers
  logic                 s1_clear_q;
  logic                 s1_in_grid_q;
  logic [CellW-1:0]     s1_cell_q;
  logic [ID_W-1:0]      s1_id_q;
  logic [WordW-1:0]     rd_word_q;
  logic [CellW-1:0]     fw_addr_q;
  logic [WordW-1:0]     fw_word_q;

  logic                 accept;
  logic signed [POS_W:0] tx, ty;
  logic [COORD_W-1:0]   col, row;
  logic                 in_grid;
  logic [CellW-1:0]     cell_addr;

  logic [WordW-1:0]     cur_word;
  logic [CntW-1:0]      n;
  logic [CntW-1:0]      limit_eff;
  logic                 full;
  logic                 store;
  logic                 we;
  logic [CellW-1:0]     waddr;
  logic [WordW-1:0]     wword;

  assign busy_o = sweep_q;
  assign accept = start_i && !busy_o;

  // grid coordinates of the incoming position
  assign tx        = $signed({pos_x_i[POS_W-1], pos_x_i}) + GRID_OFFSET;
  assign ty        = $signed({pos_y_i[POS_W-1], pos_y_i}) + GRID_OFFSET;
  assign col       = tx[COORD_SHIFT +: COORD_W];
  assign row       = ty[COORD_SHIFT +: COORD_W];
  assign in_grid   = !tx[POS_W] && !ty[POS_W]
                     && (32'(col) < 32'(GRID_SIDE)) && (32'(row) < 32'(GRID_SIDE));
  assign cell_addr = CellW'(32'(row) * 32'(GRID_SIDE) + 32'(col));

  // count word of the cell in flight, forwarded from last cycle's write
  assign cur_word = (fw_valid_q && (fw_addr_q == s1_cell_q)) ? fw_word_q : rd_word_q;
  assign n        = (cur_word[CntW +: TAG_W] == epoch_q) ? cur_word[CntW-1:0] : '0;

  // effective limit, clamped to one and the slot count
  always_comb begin
    if (cell_limit_q == '0) begin
      limit_eff = CntW'(1);
    end else if (32'(cell_limit_q) > 32'(SLOTS_PER_CELL)) begin
      limit_eff = CntW'(SLOTS_PER_CELL);
    end else begin
      limit_eff = CntW'(cell_limit_q);
    end
  end

  assign full  = (n >= limit_eff);
  assign store = s1_valid_q && !s1_clear_q && s1_in_grid_q && !full;

  // count memory write port, shared by sweep and store
  always_comb begin
    if (sweep_q) begin
      we    = 1'b1;
      waddr = sweep_addr_q;
      wword = '0;
    end else begin
      we    = store;
      waddr = s1_cell_q;
      wword = {epoch_q, CntW'(n + CntW'(1))};
    end
  end

  // sweep and frame tag
  always_comb begin
    sweep_d      = sweep_q;
    sweep_addr_d = sweep_addr_q;
    epoch_d      = epoch_q;
    if (sweep_q) begin
      sweep_addr_d = CellW'(sweep_addr_q + CellW'(1));
      if (32'(sweep_addr_q) == Cells - 1) begin
        sweep_d      = 1'b0;
        sweep_addr_d = '0;
      end
    end else if (accept && (operation_i == OP_CLEAR)) begin
      if (epoch_q == TagMax) begin
        epoch_d = TAG_W'(1);
        sweep_d = 1'b1;
      end else begin
        epoch_d = TAG_W'(epoch_q + TAG_W'(1));
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q      <= 1'b1;
      sweep_addr_q <= '0;
      epoch_q      <= TAG_W'(1);
      cell_limit_q <= LIMIT_RESET;
      s1_valid_q   <= 1'b0;
      fw_valid_q   <= 1'b0;
    end else begin
      sweep_q      <= sweep_d;
      sweep_addr_q <= sweep_addr_d;
      epoch_q      <= epoch_d;
      s1_valid_q   <= accept;
      fw_valid_q   <= we;
      if (cfg_we_i) begin
        cell_limit_q <= cfg_wdata_i;
      end
    end
  end

  // item in flight and write forwarding payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_clear_q   <= (operation_i == OP_CLEAR);
      s1_in_grid_q <= in_grid;
      s1_cell_q    <= cell_addr;
      s1_id_q      <= object_id_i;
    end
    fw_addr_q <= waddr;
    fw_word_q <= wword;
  end

  // count memory, one read and one write port
  always_ff @(posedge clk_i) begin
    if (we) begin
      cnt_mem[waddr] <= wword;
    end
    if (accept) begin
      rd_word_q <= cnt_mem[cell_addr];
    end
  end

  // slot memory, id written into the next free slot
  always_ff @(posedge clk_i) begin
    if (store) begin
      slot_mem[SlotAddrW'(32'(s1_cell_q) * 32'(SLOTS_PER_CELL) + 32'(n))] <= s1_id_q;
    end
  end

  // result beat
  always_comb begin
    done_o       = s1_valid_q;
    cell_index_o = '0;
    slot_index_o = '0;
    status_o     = ST_STORED;
    if (s1_clear_q) begin
      status_o = ST_CLEARED;
    end else if (!s1_in_grid_q) begin
      status_o = ST_OUTSIDE;
    end else if (full) begin
      status_o     = ST_FULL;
      cell_index_o = CELLIX_W'(s1_cell_q);
    end else begin
      status_o     = ST_STORED;
      cell_index_o = CELLIX_W'(s1_cell_q);
      slot_index_o = SLOTIX_W'(n);
    end
  end

`ifndef SYNTHESIS
  // every beat gives exactly one result the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(accept))
    else $error("result strobe does not follow accepted beat");

  // a stored id lands below the effective limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_STORED)) |-> (n < limit_eff))
    else $error("id stored beyond cell limit");

  // sweep never overlaps an insert write-back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep_q |-> !store)
    else $error("store during sweep");

  // a clear always moves the frame tag, never to the swept value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (operation_i == OP_CLEAR)) |=> (epoch_q != $past(epoch_q)) && (epoch_q != '0))
    else $error("clear did not advance frame tag");
`endif

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// testbench: self-checking bench for the uniform grid binner
// directed table followed by random phases, each result checked against its pinned table entry or a scoreboard model
// depends on ugb_pkg and uniform_grid_binning
`timescale 1ns / 1ps

module testbench;
  import ugb_pkg::*;

  localparam int GRID_SIDE  = 48;
  localparam int SLOT_MAX   = 8;
  localparam int CELL_TOTAL = GRID_SIDE * GRID_SIDE;
  localparam int GRID_BIAS  = 24576;
  localparam int CELL_SPAN  = 1024;
  localparam int SPAN_SHIFT = 10;
  localparam int PHASE_CNT  = 5;

  // handy Q2.14 positions at the grid edges and the centre
  localparam logic [POS_W-1:0] POS_LEFT  = 16'hA000;
  localparam logic [POS_W-1:0] POS_RIGHT = 16'h5FFF;
  localparam logic [POS_W-1:0] POS_PAST  = 16'h6000;
  localparam logic [POS_W-1:0] POS_SHORT = 16'h9FFF;
  localparam logic [POS_W-1:0] POS_ZERO  = 16'h0000;

  typedef enum logic {ROW_ITEM, ROW_LIMIT} row_kind_e;

  typedef struct packed {
    logic [CELLIX_W-1:0] cell_ix;
    logic [SLOTIX_W-1:0] slot_ix;
    logic [STATUS_W-1:0] status;
  } bin_result_t;

  typedef struct packed {
    row_kind_e          kind;
    logic               op;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [ID_W-1:0]    id;
    logic [LIMIT_W-1:0] lim;
    logic               pinned;
    bin_result_t        res;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic                operation_i;
  logic [POS_W-1:0]    pos_x_i;
  logic [POS_W-1:0]    pos_y_i;
  logic [ID_W-1:0]     object_id_i;
  logic                cfg_we_i;
  logic [LIMIT_W-1:0]  cfg_wdata_i;
  logic                done_o;
  logic [CELLIX_W-1:0] cell_index_o;
  logic [SLOTIX_W-1:0] slot_index_o;
  logic [STATUS_W-1:0] status_o;

  // expectation typed into the table travels with the beat
  logic        pin_on;
  bin_result_t pin_res;
  bit          gaps_on;

  // scoreboard copy of the grid occupancy
  bit              cell_live [CELL_TOTAL];
  int unsigned     cell_fill [CELL_TOTAL];
  logic [LIMIT_W-1:0] limit_shadow;
  bin_result_t     pending_bins [$];

  int mismatches;
  int beats_in;
  int beats_out;
  int status_tally [4];

  // directed rows: edges of the grid, every status, limit clamping and lowering
  stim_row_t dir_rows [27] = '{
    '{ROW_ITEM,  OP_INSERT, POS_LEFT,  POS_LEFT,  10'h000, 4'd0,  1'b1, '{12'd0, 3'd0, ST_STORED}},
    '{ROW_ITEM,  OP_INSERT, POS_LEFT,  POS_LEFT,  10'h3FF, 4'd0,  1'b1, '{12'd0, 3'd1, ST_STORED}},
    '{ROW_ITEM,  OP_INSERT, POS_RIGHT, POS_RIGHT, 10'h2AA, 4'd0,  1'b1,
      '{12'd2303, 3'd0, ST_STORED}},
    '{ROW_ITEM,  OP_INSERT, POS_RIGHT, POS_LEFT,  10'h155, 4'd0,  1'b1,
      '{12'd47, 3'd0, ST_STORED}},
    '{ROW_ITEM,  OP_INSERT, POS_LEFT,  POS_RIGHT, 10'h3FF, 4'd0,  1'b1,
      '{12'd2256, 3'd0, ST_STORED}},
    '{ROW_ITEM,  OP_INSERT, POS_PAST,  POS_ZERO,  10'h000, 4'd0,  1'b1, '{12'd0, 3'd0, ST_OUTSIDE}},
    '{ROW_ITEM,  OP_INSERT, POS_SHORT, POS_ZERO,  10'h000, 4'd0,  1'b1, '{12'd0, 3'd0, ST_OUTSIDE}},
    '{ROW_ITEM,  OP_INSERT, POS_ZERO,  16'h7FFF,  10'h000, 4'd0,  1'b1, '{12'd0, 3'd0, ST_OUTSIDE}},
    '{ROW_ITEM,  OP_INSERT, POS_ZERO,  16'h8000,  10'h000, 4'd0,  1'b1, '{12'd0, 3'd0, ST_OUTSIDE}},
    '{ROW_ITEM,  OP_INSERT, 16'h7FFF,  16'h8000,  10'h000, 4'd0,  1'b1, '{12'd0, 3'd0, ST_OUTSIDE}},
    '{ROW_ITEM,  OP_INSERT, POS_ZERO,  POS_ZERO,  10'h155, 4'd0,  1'b1,
      '{12'd1176, 3'd0, ST_STORED}},
    '{ROW_ITEM,  OP_INSERT, 16'hFFFF,  16'hFFFF,  10'h2AA, 4'd0,  1'b1,
      '{12'd1127, 3'd0, ST_STORED}},
    '{ROW_ITEM,  OP_INSERT, 16'h03FF,  16'h03FF,  10'h000, 4'd0,  1'b0, '0},
    '{ROW_ITEM,  OP_CLEAR,  16'hFFFF,  16'hFFFF,  10'h3FF, 4'd0,  1'b1, '{12'd0, 3'd0, ST_CLEARED}},
    '{ROW_ITEM,  OP_INSERT, POS_ZERO,  POS_ZERO,  10'h001, 4'd0,  1'b1,
      '{12'd1176, 3'd0, ST_STORED}},
    '{ROW_LIMIT, OP_INSERT, POS_ZERO,  POS_ZERO,  10'h000, 4'd1,  1'b0, '0},
    '{ROW_ITEM,  OP_INSERT, POS_ZERO,  POS_ZERO,  10'h002, 4'd0,  1'b1, '{12'd1176, 3'd0, ST_FULL}},
    '{ROW_ITEM,  OP_INSERT, 16'h03FF,  16'h03FF,  10'h003, 4'd0,  1'b1, '{12'd1176, 3'd0, ST_FULL}},
    '{ROW_LIMIT, OP_INSERT, POS_ZERO,  POS_ZERO,  10'h000, 4'd0,  1'b0, '0},
    '{ROW_ITEM,  OP_INSERT, POS_LEFT,  POS_LEFT,  10'h004, 4'd0,  1'b1, '{12'd0, 3'd0, ST_STORED}},
    '{ROW_ITEM,  OP_INSERT, POS_LEFT,  POS_LEFT,  10'h005, 4'd0,  1'b1, '{12'd0, 3'd0, ST_FULL}},
    '{ROW_LIMIT, OP_INSERT, POS_ZERO,  POS_ZERO,  10'h000, 4'd15, 1'b0, '0},
    '{ROW_ITEM,  OP_INSERT, POS_LEFT,  POS_LEFT,  10'h006, 4'd0,  1'b1, '{12'd0, 3'd1, ST_STORED}},
    '{ROW_LIMIT, OP_INSERT, POS_ZERO,  POS_ZERO,  10'h000, 4'd1,  1'b0, '0},
    '{ROW_ITEM,  OP_INSERT, POS_LEFT,  POS_LEFT,  10'h007, 4'd0,  1'b0, '0},
    '{ROW_LIMIT, OP_INSERT, POS_ZERO,  POS_ZERO,  10'h000, 4'd8,  1'b0, '0},
    '{ROW_ITEM,  OP_INSERT, POS_LEFT,  POS_LEFT,  10'h008, 4'd0,  1'b0, '0}
  };

  // hot cells that random inserts pile into
  int hot_col [6] = '{0, 47, 24, 47, 5, 24};
  int hot_row [6] = '{0, 47, 24, 0, 30, 25};

  // random phases: item count, clear share in percent
  int phase_len [PHASE_CNT] = '{160, 160, 120, 100, 560};
  int phase_clr [PHASE_CNT] = '{3, 3, 3, 3, 50};

  uniform_grid_binning dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .operation_i  (operation_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .object_id_i  (object_id_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .done_o       (done_o),
    .cell_index_o (cell_index_o),
    .slot_index_o (slot_index_o),
    .status_o     (status_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // grid coordinate of one Q2.14 axis, -1 when off the grid
  function automatic int grid_coord(logic [POS_W-1:0] raw);
    int t;
    t = int'($signed(raw)) + GRID_BIAS;
    if (t < 0) return -1;
    t = t >> SPAN_SHIFT;
    if (t >= GRID_SIDE) return -1;
    return t;
  endfunction

  // bin one object into the scoreboard grid and return its result
  function automatic bin_result_t bin_object(logic op, logic [POS_W-1:0] x,
                                             logic [POS_W-1:0] y);
    int col;
    int row;
    int cell_no;
    int lim;
    int fill;
    bin_result_t r;
    r = '0;
    if (op == OP_CLEAR) begin
      foreach (cell_live[i]) cell_live[i] = 1'b0;
      r.status = ST_CLEARED;
      return r;
    end
    col = grid_coord(x);
    row = grid_coord(y);
    if (col < 0 || row < 0) begin
      r.status = ST_OUTSIDE;
      return r;
    end
    cell_no = row * GRID_SIDE + col;
    // limit clamps to 1..SLOT_MAX
    lim = int'(limit_shadow);
    if (lim < 1) lim = 1;
    if (lim > SLOT_MAX) lim = SLOT_MAX;
    fill = cell_live[cell_no] ? cell_fill[cell_no] : 0;
    r.cell_ix = CELLIX_W'(cell_no);
    if (fill >= lim) begin
      r.status = ST_FULL;
      return r;
    end
    cell_fill[cell_no] = fill + 1;
    cell_live[cell_no] = 1'b1;
    r.slot_ix = SLOTIX_W'(fill);
    r.status  = ST_STORED;
    return r;
  endfunction

  // sample beats, config writes and results at the rising edge
  bin_result_t want;
  bin_result_t got;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        got = '{cell_index_o, slot_index_o, status_o};
        beats_out++;
        if (pending_bins.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual cell %0d slot %0d status %0d",
                   $time, got.cell_ix, got.slot_ix, got.status);
          mismatches++;
        end else begin
          want = pending_bins.pop_front();
          if (got.cell_ix !== want.cell_ix) begin
            $display("%0t: cell_index expected %0d actual %0d", $time, want.cell_ix, got.cell_ix);
            mismatches++;
          end
          if (got.slot_ix !== want.slot_ix) begin
            $display("%0t: slot_index expected %0d actual %0d", $time, want.slot_ix, got.slot_ix);
            mismatches++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            mismatches++;
          end
        end
      end
      if (cfg_we_i) limit_shadow = cfg_wdata_i;
      if (start_i && !busy_o) begin
        want = bin_object(operation_i, pos_x_i, pos_y_i);
        if (pin_on) want = pin_res;
        pending_bins = {pending_bins, want};
        status_tally[want.status]++;
        beats_in++;
      end
    end
  end

  // present one item from a falling edge until it is taken
  task automatic send_beat(input logic op, input logic [POS_W-1:0] x,
                           input logic [POS_W-1:0] y, input logic [ID_W-1:0] id,
                           input logic pin, input bin_result_t res);
    while (gaps_on && $urandom_range(0, 99) < 13) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i     <= 1'b1;
    operation_i <= op;
    pos_x_i     <= x;
    pos_y_i     <= y;
    object_id_i <= id;
    pin_on      <= pin;
    pin_res     <= res;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // hold off until every result is back and no sweep runs
  task automatic wait_quiet();
    start_i <= 1'b0;
    while (pending_bins.size() != 0 || busy_o) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    wait_quiet();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // run limit
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int k;
    int ph;
    int pick;
    int h;
    int col;
    int row;
    logic rop;
    logic [POS_W-1:0] rx;
    logic [POS_W-1:0] ry;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    operation_i  = OP_INSERT;
    pos_x_i      = '0;
    pos_y_i      = '0;
    object_id_i  = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    pin_on       = 1'b0;
    pin_res      = '0;
    gaps_on      = 1'b1;
    limit_shadow = LIMIT_RESET;
    mismatches   = 0;
    beats_in     = 0;
    beats_out    = 0;
    foreach (status_tally[i]) status_tally[i] = 0;
    foreach (cell_live[i]) cell_live[i] = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_LIMIT) write_limit(dir_rows[i].lim);
      else send_beat(dir_rows[i].op, dir_rows[i].x, dir_rows[i].y, dir_rows[i].id,
                     dir_rows[i].pinned, dir_rows[i].res);
    end

    // random phases, first one lowers the limit to a random value from 2 to 7
    for (ph = 0; ph < PHASE_CNT; ph++) begin
      case (ph)
        0: write_limit(LIMIT_W'($urandom_range(2, 7)));
        1: write_limit(4'd15);
        2: write_limit(4'd1);
        3: write_limit(4'd0);
        default: write_limit(LIMIT_RESET);
      endcase
      // one long stretch without gaps
      gaps_on = (ph != 1);
      for (k = 0; k < phase_len[ph]; k++) begin
        if (ph == 0 && k == phase_len[ph] / 2) wait_quiet();
        rop  = ($urandom_range(0, 99) < phase_clr[ph]) ? OP_CLEAR : OP_INSERT;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          h   = $urandom_range(0, 5);
          col = hot_col[h];
          row = hot_row[h];
        end else begin
          col = $urandom_range(0, GRID_SIDE - 1);
          row = $urandom_range(0, GRID_SIDE - 1);
        end
        rx = POS_W'(col * CELL_SPAN - GRID_BIAS + int'($urandom_range(0, CELL_SPAN - 1)));
        ry = POS_W'(row * CELL_SPAN - GRID_BIAS + int'($urandom_range(0, CELL_SPAN - 1)));
        // raw positions, mostly still on the grid
        if (pick >= 85) rx = POS_W'($urandom);
        if (pick >= 92) ry = POS_W'($urandom);
        send_beat(rop, rx, ry, ID_W'($urandom), 1'b0, '0);
      end
    end

    // drain, then keep watching for stray beats
    start_i <= 1'b0;
    for (k = 0; k < 200 && pending_bins.size() != 0; k++) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (pending_bins.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_bins.size());
      mismatches += pending_bins.size();
    end

    $display("binned %0d items: %0d stored, %0d dropped full, %0d off grid, %0d clears",
             beats_in, status_tally[ST_STORED], status_tally[ST_FULL],
             status_tally[ST_OUTSIDE], status_tally[ST_CLEARED]);
    $display("limits 0..15 incl. clamped and lowered, %0d result beats checked", beats_out);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
